// ===== rtl/core/sto_pkg.sv =====
package sto_pkg;

	// Coordinate format and the widths that follow from it.
	localparam int CW   = 32;            // coordinate width, signed Q16.16
	localparam int DW   = CW + 1;        // difference of two coordinates
	localparam int PW   = 2 * DW;        // product of two differences
	localparam int CRW  = PW + 1;        // cross product or squared length
	localparam int MIW  = CRW + 1;       // multiplier input, even width
	localparam int LW   = MIW / 2;       // multiplier limb width
	localparam int SQW  = 2 * CRW;       // square of a cross product

	// Cross products: three for the segment line, three per triangle edge.
	localparam int NCR  = 12;
	// Squared lengths: the segment and each triangle edge.
	localparam int NLEN = 4;
	// Squared distances that are compared: segment line and edge endpoints.
	localparam int NSQ  = 9;

	// Configuration port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int TOL_W  = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;
	localparam logic [ADDR_W-3:0] REG_TOL = '0;

endpackage

// ===== rtl/core/sto_pair_if.sv =====
interface sto_pair_if import sto_pkg::*; ;
	logic valid;
	logic ready;
	logic signed [CW-1:0] seg_start_x;
	logic signed [CW-1:0] seg_start_y;
	logic signed [CW-1:0] seg_end_x;
	logic signed [CW-1:0] seg_end_y;
	logic signed [CW-1:0] tri_a_x;
	logic signed [CW-1:0] tri_a_y;
	logic signed [CW-1:0] tri_b_x;
	logic signed [CW-1:0] tri_b_y;
	logic signed [CW-1:0] tri_c_x;
	logic signed [CW-1:0] tri_c_y;

	modport source (
		output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		output tri_a_x, tri_a_y, tri_b_x, tri_b_y, tri_c_x, tri_c_y,
		input  ready
	);
	modport sink (
		input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		input  tri_a_x, tri_a_y, tri_b_x, tri_b_y, tri_c_x, tri_c_y,
		output ready
	);
endinterface

// ===== rtl/core/sto_res_if.sv =====
interface sto_res_if;
	logic valid;
	logic ready;
	logic may_overlap;

	modport source (output valid, may_overlap, input ready);
	modport sink (input valid, may_overlap, output ready);
endinterface

// ===== rtl/core/sto_mul.sv =====
module sto_mul import sto_pkg::*; (
	input  logic                  clk,
	input  logic                  en_s4,
	input  logic                  en_s5,
	input  logic signed [CRW-1:0] a,
	input  logic signed [CRW-1:0] b,
	output logic signed [SQW-1:0] p
);

	logic signed [MIW-1:0]    ae, be;
	logic signed [LW:0]       al, bl;
	logic signed [LW-1:0]     ah, bh;
	logic signed [2*LW+1:0]   pp_ll_s4;
	logic signed [2*LW:0]     pp_lh_s4, pp_hl_s4;
	logic signed [2*LW-1:0]   pp_hh_s4;
	logic signed [2*MIW-1:0]  t_ll, t_mid, t_hh, sum;

	// Split each operand into an unsigned low limb and a signed high limb.
	assign ae = MIW'(a);
	assign be = MIW'(b);
	assign al = $signed({1'b0, ae[LW-1:0]});
	assign bl = $signed({1'b0, be[LW-1:0]});
	assign ah = ae[MIW-1:LW];
	assign bh = be[MIW-1:LW];

	// First stage: four limb products.
	always_ff @(posedge clk) begin
		if (en_s4) begin
			pp_ll_s4 <= al * bl;
			pp_lh_s4 <= al * bh;
			pp_hl_s4 <= ah * bl;
			pp_hh_s4 <= ah * bh;
		end
	end

	// Second stage: align and add the limb products.
	assign t_ll  = (2*MIW)'(pp_ll_s4);
	assign t_mid = ((2*MIW)'(pp_lh_s4) + (2*MIW)'(pp_hl_s4)) <<< LW;
	assign t_hh  = (2*MIW)'(pp_hh_s4) <<< (2*LW);
	assign sum   = t_ll + t_mid + t_hh;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			p <= sum[SQW-1:0];
		end
	end

endmodule

// ===== rtl/core/segment_triangle_overlap_test.sv =====
// Channel  | Dir | Word
// ---------+-----+-----------------------------------------------------
// pair     | in  | segment endpoints and triangle vertices, Q16.16
// result   | out | may_overlap: 1 when no separating axis was found
// APB      | in  | overlap_tolerance at byte address 0
//
// Six register stages: differences, products, cross products, two stages of
// limb multiplication for the squared distances and thresholds, then compare and decide.
// A new pair is taken every cycle unless every stage is full and the result is blocked.
// Each stage holds only when it is full and the stage after it is blocked,
// so bubbles close up; the ready path runs combinationally from result to pair.
// arst_n clears the stage valid bits and loads the tolerance with 66.
module segment_triangle_overlap_test import sto_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	sto_pair_if.sink          pair,
	sto_res_if.source         result
);

	logic [TOL_W-1:0] tol_q;
	logic [6:1]       adv;
	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [CW-1:0] sx [2];
	logic signed [CW-1:0] sy [2];
	logic signed [CW-1:0] vx [3];
	logic signed [CW-1:0] vy [3];

	logic signed [DW-1:0] ax_d [NCR];
	logic signed [DW-1:0] ay_d [NCR];
	logic signed [DW-1:0] bx_d [NCR];
	logic signed [DW-1:0] by_d [NCR];
	logic signed [DW-1:0] lx_d [NLEN];
	logic signed [DW-1:0] ly_d [NLEN];
	logic [2:0]           ez_d;

	logic signed [DW-1:0] ax_s1 [NCR];
	logic signed [DW-1:0] ay_s1 [NCR];
	logic signed [DW-1:0] bx_s1 [NCR];
	logic signed [DW-1:0] by_s1 [NCR];
	logic signed [DW-1:0] lx_s1 [NLEN];
	logic signed [DW-1:0] ly_s1 [NLEN];
	logic [2:0]           ez_s1;

	logic signed [PW-1:0] pa_s2 [NCR];
	logic signed [PW-1:0] pb_s2 [NCR];
	logic signed [PW-1:0] lx2_s2 [NLEN];
	logic signed [PW-1:0] ly2_s2 [NLEN];
	logic [2*TOL_W-1:0]   tol2_s2;
	logic [2:0]           ez_s2;

	logic signed [CRW-1:0] cr_s3 [NCR];
	logic signed [CRW-1:0] len_s3 [NLEN];
	logic [2*TOL_W-1:0]    tol2_s3;
	logic [2:0]            ez_s3;

	logic [NCR-1:0] neg_s4, neg_s5;
	logic [2:0]     ez_s4, ez_s5;

	logic signed [SQW-1:0] sq [NSQ];
	logic signed [SQW-1:0] thr [NLEN];
	logic [NSQ-1:0]        big;
	logic [3:0]            sep;
	logic                  may_s6;

	// Configuration register; writes complete in the access phase.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_TOL) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end
	assign prdata = (paddr[ADDR_W-1:2] == REG_TOL) ? DATA_W'(tol_q) : '0;

	// Stage advance: a stage loads when it is empty or the next one moves.
	assign adv[6] = !vld_s6 || result.ready;
	assign adv[5] = !vld_s5 || adv[6];
	assign adv[4] = !vld_s4 || adv[5];
	assign adv[3] = !vld_s3 || adv[4];
	assign adv[2] = !vld_s2 || adv[3];
	assign adv[1] = !vld_s1 || adv[2];
	assign pair.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv[1]) vld_s1 <= pair.valid;
			if (adv[2]) vld_s2 <= vld_s1;
			if (adv[3]) vld_s3 <= vld_s2;
			if (adv[4]) vld_s4 <= vld_s3;
			if (adv[5]) vld_s5 <= vld_s4;
			if (adv[6]) vld_s6 <= vld_s5;
		end
	end

	// Input coordinates.
	assign sx[0] = pair.seg_start_x;
	assign sy[0] = pair.seg_start_y;
	assign sx[1] = pair.seg_end_x;
	assign sy[1] = pair.seg_end_y;
	assign vx[0] = pair.tri_a_x;
	assign vy[0] = pair.tri_a_y;
	assign vx[1] = pair.tri_b_x;
	assign vy[1] = pair.tri_b_y;
	assign vx[2] = pair.tri_c_x;
	assign vy[2] = pair.tri_c_y;

	// Operand differences for every cross product and squared length.
	assign lx_d[0] = DW'(sx[1]) - DW'(sx[0]);
	assign ly_d[0] = DW'(sy[1]) - DW'(sy[0]);

	for (genvar i = 0; i < 3; i++) begin : g_seg
		assign ax_d[i] = lx_d[0];
		assign ay_d[i] = ly_d[0];
		assign bx_d[i] = DW'(vx[i]) - DW'(sx[0]);
		assign by_d[i] = DW'(vy[i]) - DW'(sy[0]);
	end

	for (genvar e = 0; e < 3; e++) begin : g_edge
		localparam int J  = (e + 1) % 3;
		localparam int K  = (e + 2) % 3;
		localparam int CB = 3 + 3 * e;

		assign lx_d[e+1] = DW'(vx[J]) - DW'(vx[e]);
		assign ly_d[e+1] = DW'(vy[J]) - DW'(vy[e]);
		assign ez_d[e]   = (lx_d[e+1] == '0) && (ly_d[e+1] == '0);

		// Third vertex sets the inward side.
		assign bx_d[CB] = DW'(vx[K]) - DW'(vx[e]);
		assign by_d[CB] = DW'(vy[K]) - DW'(vy[e]);
		for (genvar p = 0; p < 2; p++) begin : g_pt
			assign bx_d[CB+1+p] = DW'(sx[p]) - DW'(vx[e]);
			assign by_d[CB+1+p] = DW'(sy[p]) - DW'(vy[e]);
		end
		for (genvar c = 0; c < 3; c++) begin : g_op
			assign ax_d[CB+c] = lx_d[e+1];
			assign ay_d[CB+c] = ly_d[e+1];
		end
	end

	// Stage 1: differences.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ax_s1 <= ax_d;
			ay_s1 <= ay_d;
			bx_s1 <= bx_d;
			by_s1 <= by_d;
			lx_s1 <= lx_d;
			ly_s1 <= ly_d;
			ez_s1 <= ez_d;
		end
	end

	// Stage 2: products of differences.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < NCR; i++) begin
				pa_s2[i] <= ax_s1[i] * by_s1[i];
				pb_s2[i] <= ay_s1[i] * bx_s1[i];
			end
			for (int l = 0; l < NLEN; l++) begin
				lx2_s2[l] <= lx_s1[l] * lx_s1[l];
				ly2_s2[l] <= ly_s1[l] * ly_s1[l];
			end
			tol2_s2 <= tol_q * tol_q;
			ez_s2   <= ez_s1;
		end
	end

	// Stage 3: cross products and squared lengths.
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int i = 0; i < NCR; i++) begin
				cr_s3[i] <= CRW'(pa_s2[i]) - CRW'(pb_s2[i]);
			end
			for (int l = 0; l < NLEN; l++) begin
				len_s3[l] <= CRW'(lx2_s2[l]) + CRW'(ly2_s2[l]);
			end
			tol2_s3 <= tol2_s2;
			ez_s3   <= ez_s2;
		end
	end

	// Stages 4 and 5: signs ride along with the squaring multipliers.
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int i = 0; i < NCR; i++) begin
				neg_s4[i] <= cr_s3[i][CRW-1];
			end
			ez_s4 <= ez_s3;
		end
		if (adv[5]) begin
			neg_s5 <= neg_s4;
			ez_s5  <= ez_s4;
		end
	end

	// Squared cross products of the segment line and the edge endpoints.
	for (genvar q = 0; q < NSQ; q++) begin : g_sq
		localparam int CI = (q < 3) ? q : 4 + 3 * ((q - 3) / 2) + ((q - 3) % 2);
		localparam int LI = (q < 3) ? 0 : 1 + (q - 3) / 2;

		sto_mul u_sq (
			.clk   (clk),
			.en_s4 (adv[4]),
			.en_s5 (adv[5]),
			.a     (cr_s3[CI]),
			.b     (cr_s3[CI]),
			.p     (sq[q])
		);
		// The distance exceeds the tolerance.
		assign big[q] = thr[LI] < sq[q];
	end

	// Squared tolerance scaled by each squared length.
	for (genvar l = 0; l < NLEN; l++) begin : g_thr
		sto_mul u_thr (
			.clk   (clk),
			.en_s4 (adv[4]),
			.en_s5 (adv[5]),
			.a     ($signed(CRW'(tol2_s3))),
			.b     (len_s3[l]),
			.p     (thr[l])
		);
	end

	// Separating axes: the segment line, then each nondegenerate edge.
	assign sep[0] = (big[0] && big[1] && big[2] && neg_s5[0] && neg_s5[1] && neg_s5[2])
		|| (big[0] && big[1] && big[2] && !neg_s5[0] && !neg_s5[1] && !neg_s5[2]);

	for (genvar e = 0; e < 3; e++) begin : g_sep
		localparam int CB = 3 + 3 * e;
		localparam int QB = 3 + 2 * e;
		logic flip, in0, in1;

		assign flip = neg_s5[CB];
		assign in0  = big[QB] && (flip == neg_s5[CB+1]);
		assign in1  = big[QB+1] && (flip == neg_s5[CB+2]);
		assign sep[e+1] = !ez_s5[e] && !in0 && !in1;
	end

	// Stage 6: result register.
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			may_s6 <= ~|sep;
		end
	end

	assign result.valid       = vld_s6;
	assign result.may_overlap = may_s6;

	// An accepted pair always occupies the first stage next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pair.valid && pair.ready |=> vld_s1)
		else $error("accepted pair did not enter the first stage");

	// A blocked result holds its word.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && !result.ready |=> vld_s6 && $stable(may_s6))
		else $error("stalled result changed");

	// Input back-pressure only when every stage is full.
	a_full_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!pair.ready |-> vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6)
		else $error("input stalled with a free stage");

endmodule

// ===== sim/sto_overlap_checker.sv =====
module sto_overlap_checker import sto_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	sto_pair_if               pair,
	sto_res_if                result,
	output int                mismatches,
	output int                verdicts_due
);

	// Wide enough for the square of any cross product, so nothing wraps.
	typedef logic signed [159:0] wide_t;

	logic [TOL_W-1:0] tol_copy;
	logic             verdict_q[$];

	function automatic wide_t cross2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
		return ax * by - ay * bx;
	endfunction

	// Separating-axis decision: 1 means no separating axis was found.
	function automatic logic overlap_verdict(logic [TOL_W-1:0] tol);
		wide_t sx[2];
		wide_t sy[2];
		wide_t vx[3];
		wide_t vy[3];
		wide_t tolw, tol2, dx, dy, ex, ey, thr, s, c;
		int    below, above, j, k;
		logic  flip, endpoint_in;
		sx[0] = pair.seg_start_x;
		sy[0] = pair.seg_start_y;
		sx[1] = pair.seg_end_x;
		sy[1] = pair.seg_end_y;
		vx[0] = pair.tri_a_x;
		vy[0] = pair.tri_a_y;
		vx[1] = pair.tri_b_x;
		vy[1] = pair.tri_b_y;
		vx[2] = pair.tri_c_x;
		vy[2] = pair.tri_c_y;
		tolw = {144'd0, tol};
		tol2 = tolw * tolw;
		below = 0;
		above = 0;

		// The segment's own line separates when all vertices lie well beyond it.
		dx = sx[1] - sx[0];
		dy = sy[1] - sy[0];
		thr = tol2 * (dx * dx + dy * dy);
		for (int i = 0; i < 3; i++) begin
			s = cross2(dx, dy, vx[i] - sx[0], vy[i] - sy[0]);
			if (thr < s * s) begin
				if (s < 0) below++;
				else if (s > 0) above++;
			end
		end
		if (below == 3 || above == 3) return 1'b0;

		// Each nondegenerate triangle edge separates unless an endpoint lies clearly inside it.
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			ex = vx[j] - vx[i];
			ey = vy[j] - vy[i];
			if (ex == 0 && ey == 0) continue;
			thr = tol2 * (ex * ex + ey * ey);
			flip = cross2(ex, ey, vx[k] - vx[i], vy[k] - vy[i]) < 0;
			endpoint_in = 1'b0;
			for (int p = 0; p < 2; p++) begin
				c = cross2(ex, ey, sx[p] - vx[i], sy[p] - vy[i]);
				if (flip) c = -c;
				if (c > 0 && thr < c * c) endpoint_in = 1'b1;
			end
			if (!endpoint_in) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	initial mismatches = 0;

	// Track the tolerance, predict each accepted pair and check each result word.
	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			tol_copy = TOL_RESET;
			verdict_q.delete();
			verdicts_due <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_TOL)
				tol_copy = pwdata[TOL_W-1:0];
			if (pair.valid && pair.ready)
				verdict_q = {verdict_q, overlap_verdict(tol_copy)};
			if (result.valid && result.ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("result word with no pair outstanding");
				end else begin
					want = verdict_q.pop_front();
					if (result.may_overlap !== want)
						report_mismatch($sformatf("may_overlap %b, expected %b",
							result.may_overlap, want));
				end
			end
			verdicts_due <= verdict_q.size();
		end
	end

endmodule

// ===== sim/tb_segment_triangle_overlap_test.sv =====
module tb_segment_triangle_overlap_test import sto_pkg::*; ;

	localparam int ONE = 65536;
	localparam int STALL_LIMIT = 20000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                mismatches;
	int                verdicts_due;
	int                tx_idle_pct;
	int                rx_idle_pct;
	int                pairs_sent;
	int                quiet_cycles;
	bit                hold_req;
	bit                hold_done;

	sto_pair_if pair ();
	sto_res_if  result ();

	segment_triangle_overlap_test dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.pair(pair.sink), .result(result.source)
	);

	sto_overlap_checker u_checker (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.pair(pair), .result(result), .mismatches, .verdicts_due
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog: too many cycles without any word moving ends the run.
	always @(posedge clk) begin
		if ((pair.valid && pair.ready) || (result.valid && result.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off to back the pipe up.
	initial begin
		result.ready <= 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				result.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end
			result.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one pair and hold it until taken, then maybe leave a gap.
	task automatic send_pair(int v[10]);
		pair.seg_start_x <= v[0];
		pair.seg_start_y <= v[1];
		pair.seg_end_x   <= v[2];
		pair.seg_end_y   <= v[3];
		pair.tri_a_x     <= v[4];
		pair.tri_a_y     <= v[5];
		pair.tri_b_x     <= v[6];
		pair.tri_b_y     <= v[7];
		pair.tri_c_x     <= v[8];
		pair.tri_c_y     <= v[9];
		pair.valid       <= 1'b1;
		do @(posedge clk); while (!pair.ready);
		pairs_sent++;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			pair.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Mostly small coordinates near each other, with full-range and extreme values.
	task automatic send_random_pair();
		int v[10];
		int pick;
		for (int i = 0; i < 10; i++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				v[i] = $urandom;
			else if (pick == 1)
				case ($urandom_range(0, 3))
					0: v[i] = 32'h8000_0000;
					1: v[i] = 32'h7fff_ffff;
					2: v[i] = 0;
					default: v[i] = -1;
				endcase
			else if (pick <= 4 && i >= 2)
				v[i] = v[i - 2 * $urandom_range(1, i / 2)] + $signed($urandom_range(0, 400)) - 200;
			else
				v[i] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		end
		send_pair(v);
	endtask

	task automatic set_idling();
		if (pairs_sent < 350) begin
			tx_idle_pct = 6;
			rx_idle_pct = 52;
		end else if (pairs_sent < 700) begin
			tx_idle_pct = 52;
			rx_idle_pct = 6;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endtask

	// Withdraw the last pair at once so that it is not taken twice, then wait.
	task automatic drain();
		pair.valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		logic [TOL_W-1:0] tols[4];
		tx_idle_pct = 6;
		rx_idle_pct = 52;
		pairs_sent = 0;
		quiet_cycles = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pair.valid <= 1'b0;
		pair.seg_start_x <= 0;
		pair.seg_start_y <= 0;
		pair.seg_end_x <= 0;
		pair.seg_end_y <= 0;
		pair.tri_a_x <= 0;
		pair.tri_a_y <= 0;
		pair.tri_b_x <= 0;
		pair.tri_b_y <= 0;
		pair.tri_c_x <= 0;
		pair.tri_c_y <= 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed cases under the reset tolerance.
		// Everything at the origin: zero-length segment and edges.
		send_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
		// Segment crossing a counter-clockwise triangle, then the clockwise one.
		send_pair('{-ONE, ONE, 3*ONE, ONE, 0, 0, 4*ONE, 0, 0, 4*ONE});
		send_pair('{-ONE, ONE, 3*ONE, ONE, 0, 0, 0, 4*ONE, 4*ONE, 0});
		// Segment far from the triangle, beside and beyond.
		send_pair('{9*ONE, 9*ONE, 12*ONE, 9*ONE, 0, 0, 4*ONE, 0, 0, 4*ONE});
		send_pair('{-ONE, -5*ONE, ONE, -5*ONE, 0, 0, 4*ONE, 0, 0, 4*ONE});
		// Segment entirely inside, then two below an edge, at the margin and just beyond it.
		send_pair('{ONE, ONE, ONE+5, ONE+7, 0, 0, 4*ONE, 0, 0, 4*ONE});
		send_pair('{-ONE, -66, 5*ONE, -66, 0, 0, 4*ONE, 0, 0, 4*ONE});
		send_pair('{-ONE, -67, 5*ONE, -67, 0, 0, 4*ONE, 0, 0, 4*ONE});
		// Zero-length segment inside and outside.
		send_pair('{ONE, ONE, ONE, ONE, 0, 0, 4*ONE, 0, 0, 4*ONE});
		send_pair('{8*ONE, 8*ONE, 8*ONE, 8*ONE, 0, 0, 4*ONE, 0, 0, 4*ONE});
		// Collinear vertices, and a triangle with a repeated vertex.
		send_pair('{ONE, -ONE, ONE, ONE, 0, 0, ONE, 0, 2*ONE, 0});
		send_pair('{ONE, -ONE, ONE, ONE, 0, 0, 0, 0, 2*ONE, 2*ONE});
		// Extremes of the coordinate range.
		send_pair('{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 0});
		send_pair('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000});
		send_pair('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000});
		send_pair('{-1, -1, -1, 0, 32'h7fff_ffff, -1, -1, 32'h7fff_ffff, 0, 0});

		// Random phases, each under a tolerance written while the pipe is empty.
		tols = '{16'd0, 16'hffff, 16'd1000, 16'd66};
		tols[3] = $urandom_range(0, 65535);
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			reg_write(ADDR_W'(REG_TOL) << 2, {16'($urandom), tols[ph]});
			if (ph == 2) reg_write(3'd4, 32'd12345);
			if (ph == 1) hold_req = 1'b1;
			for (int n = 0; n < 260; n++) begin
				set_idling();
				send_random_pair();
			end
		end
		drain();
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/sto_pkg.sv
rtl/core/sto_pair_if.sv
rtl/core/sto_res_if.sv
rtl/core/sto_mul.sv
rtl/core/segment_triangle_overlap_test.sv
sim/sto_overlap_checker.sv
sim/tb_segment_triangle_overlap_test.sv
